[rtl/lldp_tlv_locator_assert.svh]
// Assertion macros for the LLDP TLV locator.
// Expects signals clk and arst_n in the scope of use; no other dependencies.
`ifndef LLDP_TLV_LOCATOR_ASSERT_SVH
`define LLDP_TLV_LOCATOR_ASSERT_SVH

// same-cycle implication
`define LLTL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LLTL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/lltl_pkg.sv]
// Package for the LLDP TLV locator: transaction payload types and defaults.
// No dependencies.
`default_nettype none

package lltl_pkg;

	localparam int MAX_FRAME_BYTES_DEF = 2048;
	localparam int HEADER_BYTES_DEF    = 14;

	localparam int BYTE_W  = 8;
	localparam int KIND_W  = 4;
	localparam int START_W = 11;
	localparam int LEN_W   = 9;
	localparam int TYPE_W  = 7;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} in_item_t;

	typedef struct packed {
		logic               record_valid;
		logic [KIND_W-1:0]  tlv_kind;
		logic [START_W-1:0] value_start;
		logic [LEN_W-1:0]   value_length;
		logic [BYTE_W-1:0]  id_subtype;
		logic               frame_end;
	} result_t;

endpackage

`default_nettype wire

[rtl/lldp_tlv_locator.sv]
// LLDP TLV locator top level: byte input register, phase logic, result register.
// Depends on lltl_pkg and lldp_tlv_locator_assert.svh.
//
// Channel   Dir  Handshake           Payload
// in        in   in_valid/in_ready   lltl_pkg::in_item_t (data_byte, last_byte)
// out       out  out_valid/out_ready lltl_pkg::result_t
//
// One byte per cycle unless a result waits on out_ready; a transaction goes from input
// register to result register in one pass, its result loaded as the byte leaves.
// The phase update on the input register's byte is the only per-byte work.
// arst_n clears the parse state and the valid flags of the input and result registers.
// A stalled result holds the input register only when that byte yields a result;
// bytes that yield none keep flowing behind it.
`default_nettype none

module lldp_tlv_locator #(
	parameter int MAX_FRAME_BYTES = lltl_pkg::MAX_FRAME_BYTES_DEF,
	parameter int HEADER_BYTES    = lltl_pkg::HEADER_BYTES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire lltl_pkg::in_item_t in_data,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      lltl_pkg::result_t  out_data
);

	`include "lldp_tlv_locator_assert.svh"

	// offset counter holds 0 .. MAX_FRAME_BYTES-1
	localparam int OFF_W = $clog2(MAX_FRAME_BYTES);
	localparam int NXT_W = OFF_W + 1;
	localparam int EXT_W = (NXT_W > lltl_pkg::START_W) ? NXT_W : lltl_pkg::START_W;
	localparam int LEN_W = lltl_pkg::LEN_W;

	typedef enum logic [5:0] {
		PH_SKIP_HDR = 6'b000001,
		PH_TL_HIGH  = 6'b000010,
		PH_TL_LOW   = 6'b000100,
		PH_SUBTYPE  = 6'b001000,
		PH_SKIP_VAL = 6'b010000,
		PH_DONE     = 6'b100000
	} phase_t;

	// ---------------- input register ----------------
	logic               valid_s1;
	lltl_pkg::in_item_t item_s1;
	logic               go_s1;     // byte in input register is consumed this cycle
	logic               emit;      // that byte yields a result
	logic               out_free;

	assign out_free = !out_valid || out_ready;
	assign go_s1    = valid_s1 && (!emit || out_free);
	assign in_ready = !valid_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// ---------------- parse state ----------------
	logic [OFF_W-1:0]          offset_q, offset_d;
	phase_t                    phase_q, phase_d;
	logic [7:0]                hdr_high_q, hdr_high_d;
	logic [lltl_pkg::TYPE_W-1:0] type_q, type_d;
	logic [LEN_W-1:0]          len_q, len_d;
	logic [LEN_W-1:0]          skip_q, skip_d;

	// per-byte working signals
	logic [NXT_W-1:0]          nxt;
	logic [EXT_W-1:0]          start_ext;
	phase_t                    ph_eff;
	logic [lltl_pkg::TYPE_W-1:0] tl_type;
	logic [LEN_W-1:0]          tl_len;
	logic [LEN_W-1:0]          sub_len;
	logic                      rec;
	logic [lltl_pkg::KIND_W-1:0] kind;
	logic [LEN_W-1:0]          vlen;
	logic [7:0]                sub;
	lltl_pkg::result_t         res;

	assign nxt       = {1'b0, offset_q} + NXT_W'(1);
	assign start_ext = EXT_W'(nxt);
	assign tl_type   = hdr_high_q[7:1];
	assign tl_len    = {hdr_high_q[0], item_s1.data_byte};
	assign sub_len   = len_q - LEN_W'(1);

	always_comb begin
		offset_d   = offset_q;
		phase_d    = phase_q;
		hdr_high_d = hdr_high_q;
		type_d     = type_q;
		len_d      = len_q;
		skip_d     = skip_q;
		rec        = 1'b0;
		kind       = '0;
		vlen       = '0;
		sub        = '0;

		// header skip ends once the Ethernet header has gone by
		if (phase_q == PH_SKIP_HDR && 32'(offset_q) >= 32'(HEADER_BYTES)) begin
			ph_eff = PH_TL_HIGH;
		end else begin
			ph_eff = phase_q;
		end
		phase_d = ph_eff;

		unique case (ph_eff)
			PH_TL_HIGH: begin
				hdr_high_d = item_s1.data_byte;
				phase_d    = PH_TL_LOW;
			end
			PH_TL_LOW: begin
				type_d = tl_type;
				len_d  = tl_len;
				priority if (tl_type == '0) begin
					// end-of-LLDPDU TLV
					phase_d = PH_DONE;
				end else if (tl_type <= 7'd2) begin
					if (tl_len == '0) begin
						// empty ID: record at once, no subtype
						rec     = 1'b1;
						kind    = tl_type[3:0];
						phase_d = PH_TL_HIGH;
					end else begin
						phase_d = PH_SUBTYPE;
					end
				end else if (tl_type <= 7'd8) begin
					rec     = 1'b1;
					kind    = tl_type[3:0];
					vlen    = tl_len;
					skip_d  = tl_len;
					phase_d = (tl_len == '0) ? PH_TL_HIGH : PH_SKIP_VAL;
				end else begin
					skip_d  = tl_len;
					phase_d = (tl_len == '0) ? PH_TL_HIGH : PH_SKIP_VAL;
				end
			end
			PH_SUBTYPE: begin
				rec     = 1'b1;
				kind    = type_q[3:0];
				vlen    = sub_len;
				sub     = item_s1.data_byte;
				skip_d  = sub_len;
				phase_d = (sub_len == '0) ? PH_TL_HIGH : PH_SKIP_VAL;
			end
			PH_SKIP_VAL: begin
				skip_d = skip_q - LEN_W'(1);
				if (skip_q == LEN_W'(1)) begin
					phase_d = PH_TL_HIGH;
				end
			end
			default: begin
				// header skip or done: nothing to parse
			end
		endcase

		// oversize frame: freeze offset, ignore rest
		if (32'(nxt) >= 32'(MAX_FRAME_BYTES)) begin
			phase_d = PH_DONE;
		end else begin
			offset_d = nxt[OFF_W-1:0];
		end

		if (item_s1.last_byte) begin
			offset_d   = '0;
			phase_d    = PH_SKIP_HDR;
			hdr_high_d = '0;
			type_d     = '0;
			len_d      = '0;
			skip_d     = '0;
		end
	end

	assign emit = rec || item_s1.last_byte;

	always_comb begin
		res.record_valid = rec;
		res.tlv_kind     = kind;
		res.value_start  = rec ? start_ext[lltl_pkg::START_W-1:0] : '0;
		res.value_length = vlen;
		res.id_subtype   = sub;
		res.frame_end    = item_s1.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= '0;
			phase_q    <= PH_SKIP_HDR;
			hdr_high_q <= '0;
			type_q     <= '0;
			len_q      <= '0;
			skip_q     <= '0;
		end else if (go_s1) begin
			offset_q   <= offset_d;
			phase_q    <= phase_d;
			hdr_high_q <= hdr_high_d;
			type_q     <= type_d;
			len_q      <= len_d;
			skip_q     <= skip_d;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (go_s1 && emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && emit) begin
			out_data <= res;
		end
	end

	// ---------------- assertions ----------------
	`LLTL_ASSERT_IMP(a_rec_kind, out_valid && out_data.record_valid,
		out_data.tlv_kind != '0 && out_data.tlv_kind <= 4'd8, "record with bad TLV kind")
	`LLTL_ASSERT_IMP(a_norec_zero, out_valid && !out_data.record_valid,
		out_data.tlv_kind == '0 && out_data.value_length == '0 && out_data.id_subtype == '0,
		"empty result carries record fields")
	`LLTL_ASSERT_NXT(a_frame_clear, go_s1 && item_s1.last_byte,
		offset_q == '0 && phase_q == PH_SKIP_HDR, "state not cleared after frame end")
	`LLTL_ASSERT_NXT(a_result_load, go_s1 && emit,
		out_valid && out_data.frame_end == $past(item_s1.last_byte),
		"result register missed a transaction")

endmodule

`default_nettype wire

[tb/lldp_tlv_locator_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for lldp_tlv_locator: drives LLDP frames byte by byte and checks
// every TLV record against a behavioural predictor. Depends on lltl_pkg and the block RTL.

module lldp_tlv_locator_tb;

	localparam int MAX_BYTES = lltl_pkg::MAX_FRAME_BYTES_DEF;
	localparam int HDR_BYTES = lltl_pkg::HEADER_BYTES_DEF;
	localparam int RANDOM_BYTES = 760;

	localparam int BYTE_W  = lltl_pkg::BYTE_W;
	localparam int KIND_W  = lltl_pkg::KIND_W;
	localparam int START_W = lltl_pkg::START_W;
	localparam int LEN_W   = lltl_pkg::LEN_W;
	localparam int TYPE_W  = lltl_pkg::TYPE_W;

	// TLV type codes that matter to the block
	localparam logic [TYPE_W-1:0] TLV_END          = 7'd0;
	localparam logic [TYPE_W-1:0] TLV_CHASSIS_ID   = 7'd1;
	localparam logic [TYPE_W-1:0] TLV_PORT_ID      = 7'd2;
	localparam logic [TYPE_W-1:0] TLV_TTL          = 7'd3;
	localparam logic [TYPE_W-1:0] TLV_MGMT_ADDR    = 7'd8;
	localparam logic [TYPE_W-1:0] TLV_ORG_SPECIFIC = 7'd127;
	localparam logic [LEN_W-1:0]  LEN_MAX          = 9'h1FF;

	typedef enum logic [5:0] {
		PH_HEADER_SKIP  = 6'b000001,
		PH_TYPE_HIGH    = 6'b000010,
		PH_TYPE_LOW     = 6'b000100,
		PH_SUBTYPE_BYTE = 6'b001000,
		PH_VALUE_SKIP   = 6'b010000,
		PH_PARSE_DONE   = 6'b100000
	} parse_phase_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	lltl_pkg::in_item_t in_data;
	logic               out_valid;
	logic               out_ready = 1'b0;
	lltl_pkg::result_t  out_data;

	// predictor copy of the parse state
	int                  frame_offset;
	parse_phase_t        parse_state;
	logic [BYTE_W-1:0]   hdr_high;
	logic [TYPE_W-1:0]   cur_type;
	logic [LEN_W-1:0]    cur_len;
	logic [LEN_W-1:0]    skip_left;

	lltl_pkg::result_t   expected_records[$];
	logic [BYTE_W-1:0]   frame_bytes[$];
	int                  bytes_sent;
	int                  mismatch_count = 0;
	int                  idle_pct = 0;
	int                  stall_pct = 0;

	lldp_tlv_locator #(
		.MAX_FRAME_BYTES(MAX_BYTES),
		.HEADER_BYTES(HDR_BYTES)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Run limit: far beyond the slowest legal run, allowing for idling on both sides.
	initial begin
		#5_000_000;
		$display("FAIL lldp_tlv_locator");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	task automatic clear_parse_state();
		frame_offset = 0;
		parse_state  = PH_HEADER_SKIP;
		hdr_high     = '0;
		cur_type     = '0;
		cur_len      = '0;
		skip_left    = '0;
	endtask

	task automatic begin_value_skip(input logic [LEN_W-1:0] n);
		skip_left   = n;
		parse_state = (n == '0) ? PH_TYPE_HIGH : PH_VALUE_SKIP;
	endtask

	// Advance the parse by one accepted byte; queue the record (and/or frame
	// close) that the block must produce for it.
	task automatic locate_byte(input logic [BYTE_W-1:0] b, input logic is_last);
		int                  offs;
		logic                rec;
		logic [KIND_W-1:0]   kind;
		logic [START_W-1:0]  start;
		logic [LEN_W-1:0]    vlen;
		logic [BYTE_W-1:0]   sub;
		logic [15:0]         tl;
		lltl_pkg::result_t   r;

		offs  = frame_offset;
		rec   = 1'b0;
		kind  = '0;
		start = '0;
		vlen  = '0;
		sub   = '0;

		if (parse_state == PH_HEADER_SKIP && offs >= HDR_BYTES)
			parse_state = PH_TYPE_HIGH;

		case (parse_state)
			PH_TYPE_HIGH: begin
				hdr_high    = b;
				parse_state = PH_TYPE_LOW;
			end
			PH_TYPE_LOW: begin
				tl       = {hdr_high, b};
				cur_type = tl[15:9];
				cur_len  = tl[8:0];
				if (cur_type == TLV_END) begin
					parse_state = PH_PARSE_DONE;
				end else if (cur_type <= TLV_PORT_ID) begin
					// an empty ID has no subtype byte: report it straight away
					if (cur_len == '0) begin
						rec         = 1'b1;
						kind        = cur_type[KIND_W-1:0];
						start       = START_W'(offs + 1);
						parse_state = PH_TYPE_HIGH;
					end else begin
						parse_state = PH_SUBTYPE_BYTE;
					end
				end else if (cur_type <= TLV_MGMT_ADDR) begin
					rec   = 1'b1;
					kind  = cur_type[KIND_W-1:0];
					start = START_W'(offs + 1);
					vlen  = cur_len;
					begin_value_skip(cur_len);
				end else begin
					begin_value_skip(cur_len);
				end
			end
			PH_SUBTYPE_BYTE: begin
				rec   = 1'b1;
				kind  = cur_type[KIND_W-1:0];
				start = START_W'(offs + 1);
				vlen  = cur_len - 1'b1;
				sub   = b;
				begin_value_skip(vlen);
			end
			PH_VALUE_SKIP: begin
				skip_left = skip_left - 1'b1;
				if (skip_left == '0)
					parse_state = PH_TYPE_HIGH;
			end
			default: ;
		endcase

		// overlong frame: offset sticks and parsing stops until the frame ends
		if (offs + 1 >= MAX_BYTES)
			parse_state = PH_PARSE_DONE;
		else
			frame_offset = offs + 1;

		if (rec || is_last) begin
			r.record_valid = rec;
			r.tlv_kind     = kind;
			r.value_start  = start;
			r.value_length = vlen;
			r.id_subtype   = sub;
			r.frame_end    = is_last;
			expected_records.push_back(r);
		end

		if (is_last)
			clear_parse_state();
	endtask

	// ---------------------------------------------------------------- drivers

	// Receiver back-pressure, redrawn every cycle.
	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= stall_pct);
	end

	// Send one byte transaction; inputs change on the falling edge only.
	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_last);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid          = 1'b1;
		in_data.data_byte = b;
		in_data.last_byte = is_last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		locate_byte(b, is_last);
	endtask

	task automatic send_frame();
		foreach (frame_bytes[i])
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
		bytes_sent += frame_bytes.size();
	endtask

	task automatic add_random_bytes(input int n);
		repeat (n)
			frame_bytes.push_back(BYTE_W'($urandom_range(255)));
	endtask

	// TLV header: 7-bit type over 9-bit length, high byte first
	task automatic add_tlv(input logic [TYPE_W-1:0] t, input logic [LEN_W-1:0] n);
		frame_bytes.push_back({t, n[8]});
		frame_bytes.push_back(n[7:0]);
	endtask

	// ---------------------------------------------------------------- checker

	task automatic check_field(input string name, input int unsigned want_v,
			input int unsigned got_v);
		if (want_v != got_v) begin
			mismatch_count++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
		end
	endtask

	always @(posedge clk) begin
		lltl_pkg::result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_records.size() == 0) begin
				mismatch_count++;
				$display("%0t: unexpected result, expected none, actual %p", $time, out_data);
			end else begin
				want = expected_records.pop_front();
				check_field("record_valid", want.record_valid, out_data.record_valid);
				check_field("tlv_kind", want.tlv_kind, out_data.tlv_kind);
				check_field("value_start", want.value_start, out_data.value_start);
				check_field("value_length", want.value_length, out_data.value_length);
				check_field("id_subtype", want.id_subtype, out_data.id_subtype);
				check_field("frame_end", want.frame_end, out_data.frame_end);
			end
		end
	end

	// ---------------------------------------------------------------- tests

	// Hand-built frames: every record type, IDs with and without subtype,
	// skipped types, end TLV, and frames cut short at awkward points.
	task automatic test_directed_frames();
		logic [TYPE_W-1:0] t;
		idle_pct  = 0;
		stall_pct = 0;

		// full frame, header bytes at both extremes
		frame_bytes.delete();
		for (int i = 0; i < HDR_BYTES; i++)
			frame_bytes.push_back(i[0] ? 8'hFF : 8'h00);
		add_tlv(TLV_CHASSIS_ID, 9'd7);
		frame_bytes.push_back(8'h04);
		add_random_bytes(6);
		add_tlv(TLV_PORT_ID, 9'd0);          // empty ID
		add_tlv(TLV_PORT_ID, 9'd1);          // subtype only, zero-length value
		frame_bytes.push_back(8'hFF);
		for (t = TLV_TTL; t <= TLV_MGMT_ADDR; t++) begin
			add_tlv(t, 9'd1);
			add_random_bytes(1);
		end
		add_tlv(TLV_MGMT_ADDR + 1'b1, 9'd2);  // first ignored type
		add_random_bytes(2);
		add_tlv(TLV_ORG_SPECIFIC, 9'd1);
		frame_bytes.push_back(8'h5A);
		add_tlv(TLV_END, 9'd0);
		add_random_bytes(2);                 // trailing bytes after the end TLV
		send_frame();

		// longest length field, value runs past the end of the frame
		frame_bytes.delete();
		add_random_bytes(HDR_BYTES);
		add_tlv(TLV_MGMT_ADDR, LEN_MAX);
		add_random_bytes(3);
		send_frame();

		// frame ends after the first header byte
		frame_bytes.delete();
		add_random_bytes(HDR_BYTES);
		frame_bytes.push_back({TLV_TTL, 1'b0});
		send_frame();

		// frame ends right after an ID header, so no subtype
		frame_bytes.delete();
		add_random_bytes(HDR_BYTES);
		add_tlv(TLV_CHASSIS_ID, 9'd5);
		send_frame();

		// end TLV with all length bits set, then stray bytes
		frame_bytes.delete();
		add_random_bytes(HDR_BYTES);
		add_tlv(TLV_END, LEN_MAX);
		frame_bytes.push_back(8'hFF);
		frame_bytes.push_back(8'h00);
		send_frame();

		// single-byte frame, and one that is only the Ethernet header
		frame_bytes.delete();
		frame_bytes.push_back(8'hFF);
		send_frame();
		frame_bytes.delete();
		add_random_bytes(HDR_BYTES);
		send_frame();
	endtask

	// Mostly well-formed frames with random TLV mix and content; some are cut
	// short anywhere and a few never get past the Ethernet header.
	task automatic build_random_frame();
		int                pick;
		int                n_tlv;
		int                cut;
		logic [TYPE_W-1:0] t;
		logic [LEN_W-1:0]  n;

		frame_bytes.delete();
		if ($urandom_range(19) == 0) begin
			add_random_bytes($urandom_range(1, HDR_BYTES));
		end else begin
			add_random_bytes(HDR_BYTES);
			n_tlv = $urandom_range(1, 6);
			for (int k = 0; k < n_tlv; k++) begin
				pick = $urandom_range(99);
				if (pick < 25)
					t = TYPE_W'($urandom_range(TLV_CHASSIS_ID, TLV_PORT_ID));
				else if (pick < 80)
					t = TYPE_W'($urandom_range(TLV_TTL, TLV_MGMT_ADDR));
				else if (pick < 93)
					t = TYPE_W'($urandom_range(TLV_MGMT_ADDR + 1, TLV_ORG_SPECIFIC));
				else
					t = TLV_END;
				pick = $urandom_range(99);
				if (pick < 10)
					n = '0;
				else if (pick < 80)
					n = LEN_W'($urandom_range(1, 16));
				else if (pick < 95)
					n = LEN_W'($urandom_range(17, 80));
				else
					n = LEN_W'($urandom_range(256, LEN_MAX));
				add_tlv(t, n);
				if (t == TLV_END) begin
					add_random_bytes($urandom_range(0, 4));
					break;
				end
				add_random_bytes(n);
			end
			if ($urandom_range(99) < 25) begin
				cut = $urandom_range(1, frame_bytes.size());
				while (frame_bytes.size() > cut)
					void'(frame_bytes.pop_back());
			end
		end
	endtask

	// Random traffic under each mix of input idling and output stalls in turn.
	task automatic test_random_traffic();
		int idle_mix[4]  = '{0, 61, 0, 32};
		int stall_mix[4] = '{0, 0, 61, 32};
		for (int p = 0; p < 4; p++) begin
			idle_pct   = idle_mix[p];
			stall_pct  = stall_mix[p];
			bytes_sent = 0;
			while (bytes_sent < RANDOM_BYTES / 4) begin
				build_random_frame();
				send_frame();
			end
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n  = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		clear_parse_state();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_frames();
		test_random_traffic();

		@(negedge clk);
		in_valid = 1'b0;
		stall_pct = 0;
		// drain the result path, then keep watching for anything stray
		while (expected_records.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatch_count == 0 && expected_records.size() == 0)
			$display("PASS lldp_tlv_locator");
		else
			$display("FAIL lldp_tlv_locator");
		$finish;
	end

endmodule
